### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file (mpfc_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MPFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mpfc_pkg.sv
`default_nettype none

package mpfc_pkg;

    localparam int DataW   = 32;
    localparam int RandW   = 31;
    localparam int ApbAddrW = 3;

    // LCG constants, kept to the 31 bits of the sequence
    localparam logic [RandW-1:0] LcgMul = 31'd1103515245;
    localparam logic [RandW-1:0] LcgAdd = 31'd12345;

    // pattern_mode codes; code 3 behaves as random
    localparam logic [1:0] ModeConst  = 2'd0;
    localparam logic [1:0] ModeAddr   = 2'd1;
    localparam logic [1:0] ModeRandom = 2'd2;

    // operation codes
    localparam logic OpFill  = 1'b0;
    localparam logic OpCheck = 1'b1;

    // register index, taken from the word part of paddr
    localparam logic RegPatternMode = 1'b0;
    localparam logic RegFillValue   = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [DataW-1:0] word_address;
        logic [DataW-1:0] read_word;
        logic             last_word;
    } t_item;

    typedef struct packed {
        logic [DataW-1:0] pattern_word;
        logic             mismatch;
        logic             run_done;
        logic             error_found;
        logic [DataW-1:0] first_error_address;
    } t_result;

    typedef struct packed {
        logic [1:0]       pattern_mode;
        logic [DataW-1:0] fill_value;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/mpfc_cfg.sv
`default_nettype none

module mpfc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpfc_pkg::ApbAddrW-1:0] paddr,
    input  logic [mpfc_pkg::DataW-1:0]    pwdata,
    output logic [mpfc_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    output mpfc_pkg::t_cfg                o_cfg
);
    import mpfc_pkg::*;

    t_cfg r_cfg;
    logic w_write;
    logic w_index;

    // byte offset inside a word is ignored
    assign w_index = paddr[ApbAddrW-1];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_mode <= ModeConst;
            r_cfg.fill_value   <= '0;
        end else if (w_write) begin
            unique case (w_index)
                RegPatternMode: r_cfg.pattern_mode <= pwdata[1:0];
                RegFillValue:   r_cfg.fill_value   <= pwdata;
                default:        r_cfg.fill_value   <= r_cfg.fill_value;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            RegPatternMode: prdata = {{(DataW-2){1'b0}}, r_cfg.pattern_mode};
            RegFillValue:   prdata = r_cfg.fill_value;
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/mpfc_engine.sv
`default_nettype none

module mpfc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpfc_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mpfc_pkg::t_item   i_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mpfc_pkg::t_result o_result
);
    import mpfc_pkg::*;

    // input register
    logic    r_s1_valid;
    t_item   r_s1_item;
    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    // run state
    logic [RandW-1:0] r_rand;
    logic [RandW-1:0] n_rand;
    logic             r_err_seen;
    logic             n_err_seen;
    logic [DataW-1:0] r_err_addr;
    logic [DataW-1:0] n_err_addr;

    logic             w_out_load;
    logic             w_advance;
    logic             w_in_take;
    logic [RandW-1:0] w_rand_next;
    logic             w_random_mode;
    logic [DataW-1:0] w_pattern;
    logic             w_mismatch;
    logic             w_first_err;

    // result register frees up when empty or being taken
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_advance  = r_s1_valid && w_out_load;
    assign o_in_stall = r_s1_valid && !w_out_load;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // one constant multiply, low 31 bits only
    assign w_rand_next = r_rand * LcgMul + LcgAdd;

    always_comb begin
        case (i_cfg.pattern_mode)
            ModeConst: begin
                w_pattern     = i_cfg.fill_value;
                w_random_mode = 1'b0;
            end
            ModeAddr: begin
                w_pattern     = r_s1_item.word_address;
                w_random_mode = 1'b0;
            end
            default: begin
                w_pattern     = {1'b0, w_rand_next};
                w_random_mode = 1'b1;
            end
        endcase
    end

    assign w_mismatch  = (r_s1_item.operation == OpCheck) && (r_s1_item.read_word != w_pattern);
    assign w_first_err = w_mismatch && !r_err_seen;

    always_comb begin
        n_out.pattern_word        = w_pattern;
        n_out.mismatch            = w_mismatch;
        n_out.run_done            = r_s1_item.last_word;
        n_out.error_found         = r_err_seen || w_mismatch;
        n_out.first_error_address = w_first_err ? r_s1_item.word_address : r_err_addr;

        // last word clears the run
        if (r_s1_item.last_word) begin
            n_rand     = '0;
            n_err_seen = 1'b0;
            n_err_addr = '1;
        end else begin
            n_rand     = w_random_mode ? w_rand_next : r_rand;
            n_err_seen = n_out.error_found;
            n_err_addr = n_out.first_error_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rand      <= '0;
            r_err_seen  <= 1'b0;
            r_err_addr  <= '1;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_advance) begin
                r_rand     <= n_rand;
                r_err_seen <= n_err_seen;
                r_err_addr <= n_err_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_item <= i_item;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

### hw/rtl/memory_pattern_fill_check_unit.sv
// Memory test pattern engine. Feed one item per memory word: a fill step returns
// the word to write, a check step also compares read_word with the expected word
// and flags a mismatch. pattern_mode picks a constant word (fill_value), the
// word's own address, or a 31-bit LCG sequence (x*1103515245+12345 mod 2^31)
// that restarts from 0 with each run and steps once per item taken in that mode.
// The item marked last_word closes the run: its result carries run_done, whether
// any check failed and the first failing address (all ones if none), and the run
// state is cleared. Checking continues after a mismatch. Throughput is one item
// per clock unless the output stalls; an input register then the result register,
// with the LCG multiply, pattern select and compare between them. The sequence
// and error state update in that same step, so consecutive items never wait on
// each other. No clearing pass after reset. Write pattern_mode and fill_value
// over APB (offsets 0x0 and 0x4) only while no items are in flight.
`default_nettype none

module memory_pattern_fill_check_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mpfc_pkg::t_item               i_item,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mpfc_pkg::t_result             o_result,
    // register access
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpfc_pkg::ApbAddrW-1:0] paddr,
    input  logic [mpfc_pkg::DataW-1:0]    pwdata,
    output logic [mpfc_pkg::DataW-1:0]    prdata,
    output logic                          pready
);
    import mpfc_pkg::*;

    t_cfg w_cfg;

    // pattern_mode / fill_value registers
    mpfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pattern generation, compare and run state
    mpfc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

### hw/rtl/mpfc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mpfc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input mpfc_pkg::t_result             o_result
);
    import mpfc_pkg::*;

    logic             w_in_acc;
    logic             w_out_acc;
    logic [1:0]       r_count;
    logic             r_held_err;
    logic [DataW-1:0] r_held_addr;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // items in flight, and error state carried inside a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_held_err <= 1'b0;
        end else begin
            r_count <= r_count + 2'(w_in_acc) - 2'(w_out_acc);
            if (w_out_acc) begin
                r_held_err <= o_result.error_found && !o_result.run_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_held_addr <= o_result.first_error_address;
        end
    end

    `MPFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_result), "result dropped or changed while stalled")
    `MPFC_ASSERT_IMPL(a_no_phantom, i_clk, i_rst_n, o_out_valid, r_count != 2'd0, "result with no item in flight")
    `MPFC_ASSERT_IMPL(a_err_sticky, i_clk, i_rst_n, o_out_valid && r_held_err, o_result.error_found && o_result.first_error_address == r_held_addr, "first error lost within run")
    `MPFC_ASSERT_IMPL(a_clean_addr, i_clk, i_rst_n, o_out_valid && !o_result.error_found, o_result.first_error_address == '1 && !o_result.mismatch, "error address set without error")

endmodule

bind memory_pattern_fill_check_unit mpfc_checker u_checker (.*);

`default_nettype wire
